/* rtl/sphr_pkg.sv */
// ----------------------------------------------------------------------------
// sphr_pkg
// Shared widths, sequencer states and decimal tables for the power history
// ring.
// ----------------------------------------------------------------------------
package sphr_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int SAMPLE_MS_DEF = 1000;

  localparam int NOW_W  = 32;
  localparam int CNT_W  = 40;
  localparam int PWR_W  = 24;
  localparam int LAG_W  = 16;
  localparam int PLOT_W = 32;
  localparam int MANT_W = 8;
  localparam int EXP_W  = 4;
  localparam int P10_W  = 50;

  // Watt-hours to watt-milliseconds
  localparam logic [21:0] MS_PER_HOUR = 22'd3600000;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT_A,
    S_SLOT_B,
    S_DECIDE,
    S_MUL,
    S_PDIV,
    S_PSAT,
    S_EXP,
    S_MDIV,
    S_FSTART,
    S_FILL,
    S_QMUL,
    S_QOUT
  } state_t;

  function automatic logic [P10_W-1:0] pow10(input logic [EXP_W-1:0] e);
    logic [P10_W-1:0] p;
    unique case (e)
      4'd0:    p = 50'd1;
      4'd1:    p = 50'd10;
      4'd2:    p = 50'd100;
      4'd3:    p = 50'd1000;
      4'd4:    p = 50'd10000;
      4'd5:    p = 50'd100000;
      4'd6:    p = 50'd1000000;
      4'd7:    p = 50'd10000000;
      4'd8:    p = 50'd100000000;
      4'd9:    p = 50'd1000000000;
      4'd10:   p = 50'd10000000000;
      4'd11:   p = 50'd100000000000;
      4'd12:   p = 50'd1000000000000;
      4'd13:   p = 50'd10000000000000;
      4'd14:   p = 50'd100000000000000;
      default: p = 50'd1000000000000000;
    endcase
    return p;
  endfunction

  // Smallest magnitude that no longer fits the mantissa at exponent e:
  // 128*10^e for positive values, 129*10^e for negative ones.
  function automatic logic [63:0] fit_limit(input logic [EXP_W-1:0] e, input logic neg);
    logic [63:0] p;
    p = 64'(pow10(e));
    return (p << 7) + (neg ? p : 64'd0);
  endfunction

endpackage

/* rtl/sphr_if.sv */
// ----------------------------------------------------------------------------
// sphr_if
// Request and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sphr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [sphr_pkg::NOW_W-1:0]  now_ms;
  logic                        counter_estimated;
  logic [sphr_pkg::CNT_W-1:0]  import_counter_wh;
  logic [sphr_pkg::CNT_W-1:0]  export_counter_wh;
  logic [sphr_pkg::PWR_W-1:0]  import_power_w;
  logic [sphr_pkg::PWR_W-1:0]  export_power_w;
  logic [sphr_pkg::LAG_W-1:0]  lag_slots;

  modport source (
    output valid, req_type, now_ms, counter_estimated, import_counter_wh,
           export_counter_wh, import_power_w, export_power_w, lag_slots,
    input  ready
  );
  modport sink (
    input  valid, req_type, now_ms, counter_estimated, import_counter_wh,
           export_counter_wh, import_power_w, export_power_w, lag_slots,
    output ready
  );
endinterface

interface sphr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sphr_pkg::PLOT_W-1:0] plot_value;

  modport source (output valid, plot_value, input ready);
  modport sink   (input valid, plot_value, output ready);
endinterface

/* rtl/scaled_power_history_ring_top.sv */
// ----------------------------------------------------------------------------
// scaled_power_history_ring_top
// Ring of DEPTH time slots holding net power as 8-bit mantissa + decimal
// exponent; meter readings fill slots, queries read a value lags back.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the slot memory to zero, one entry per
// cycle, and holds in_req.ready low meanwhile. A request is then worked on
// alone by a sequencer; ready is high only in idle. Every request first
// finds its slot: one reciprocal multiply for time / SAMPLE_MS, then one for
// the quotient / DEPTH and a multiply-subtract for the remainder. A query
// then goes through memory read, scale and output (a lag beyond DEPTH or
// before time zero goes straight to output with 0); its result waits while
// the previous result still sits unaccepted in the output register. A reading
// adds a decide step, an exponent search, a restoring division for the
// mantissa when the exponent is nonzero, a fill start step and the fill of
// each slot after the last one up to the new one. A counter-estimated
// reading also adds a shift-add multiply by 3600000, a division by elapsed ms
// and a saturation step. Readings emit no result; the first reading only
// primes the time/counter record.
// ----------------------------------------------------------------------------
module scaled_power_history_ring_top #(
  parameter int DEPTH     = sphr_pkg::DEPTH_DEF,
  parameter int SAMPLE_MS = sphr_pkg::SAMPLE_MS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  sphr_in_if.sink     in_req,
  sphr_out_if.source  out_rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GW = AW + 2;
  localparam int MW = sphr_pkg::MANT_W + sphr_pkg::EXP_W;

  // floor(n / d) = (n * ceil(2^(32+l) / d)) >> (32+l), l = ceil(log2 d), n < 2^32
  localparam int          SLOT_SH  = 32 + $clog2(SAMPLE_MS);
  localparam logic [32:0] SLOT_RCP =
    33'(((64'd1 << SLOT_SH) + 64'(SAMPLE_MS) - 64'd1) / 64'(SAMPLE_MS));
  localparam int          RING_SH  = 32 + $clog2(DEPTH);
  localparam logic [32:0] RING_RCP =
    33'(((64'd1 << RING_SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  // slot memory: {exponent, mantissa}
  logic [MW-1:0] mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] rd_r;

  sphr_pkg::state_t state_r, state_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;

  // shared divider
  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [32:0] rem_w, rem_s;
  logic        div_ge;
  logic [63:0] dvd_s;

  logic [63:0] acc_r, acc_nxt;
  logic [41:0] dmag_r, dmag_nxt;

  // latched request
  logic        req_type_r, req_type_nxt;
  logic [31:0] now_r, now_nxt;
  logic        est_r, est_nxt;
  logic signed [40:0] net_r, net_nxt;
  logic [15:0] lag_r, lag_nxt;
  logic [31:0] back_r, back_nxt;

  logic [AW-1:0] slot_r, slot_nxt;
  logic          neg_r, neg_nxt;
  logic [31:0]   mag_r, mag_nxt;
  logic [3:0]    exp_r, exp_nxt;
  logic [7:0]    mant_r, mant_nxt;
  logic signed [58:0] prod_r, prod_nxt;

  // history record
  logic [31:0]        last_time_r, last_time_nxt;
  logic signed [40:0] last_net_r, last_net_nxt;
  logic [AW-1:0]      last_slot_r, last_slot_nxt;
  logic               primed_r, primed_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;

  // decide-step temporaries
  logic [AW-1:0]      slot_w;
  logic [31:0]        ms_w;
  logic signed [41:0] delta_w;
  logic signed [24:0] pdiff_w;
  logic [GW-1:0]      back_slot_w;
  logic [AW-1:0]      next_idx_w;

  // slot-finding products
  logic [64:0]        rcp_time_w;
  logic [64:0]        rcp_ring_w;

  assign in_req.ready       = (state_r == sphr_pkg::S_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.plot_value = out_value_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sphr_pkg::S_CLEAR;
      cnt_r       <= '0;
      idx_r       <= '0;
      last_time_r <= '0;
      last_net_r  <= '0;
      last_slot_r <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      last_time_r <= last_time_nxt;
      last_net_r  <= last_net_nxt;
      last_slot_r <= last_slot_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    dsr_r      <= dsr_nxt;
    acc_r      <= acc_nxt;
    dmag_r     <= dmag_nxt;
    req_type_r <= req_type_nxt;
    now_r      <= now_nxt;
    est_r      <= est_nxt;
    net_r      <= net_nxt;
    lag_r      <= lag_nxt;
    back_r     <= back_nxt;
    slot_r     <= slot_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    exp_r      <= exp_nxt;
    mant_r     <= mant_nxt;
    prod_r     <= prod_nxt;
    out_value_r <= out_value_nxt;
  end

  // one restoring-division step
  always_comb begin
    rem_w  = {rem_r, dvd_r[63]};
    div_ge = (rem_w >= {1'b0, dsr_r});
    rem_s  = div_ge ? (rem_w - {1'b0, dsr_r}) : rem_w;
    dvd_s  = {dvd_r[62:0], div_ge};
  end

  assign next_idx_w = (idx_r == AW'(DEPTH - 1)) ? '0 : idx_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    acc_nxt       = acc_r;
    dmag_nxt      = dmag_r;
    req_type_nxt  = req_type_r;
    now_nxt       = now_r;
    est_nxt       = est_r;
    net_nxt       = net_r;
    lag_nxt       = lag_r;
    back_nxt      = back_r;
    slot_nxt      = slot_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    exp_nxt       = exp_r;
    mant_nxt      = mant_r;
    prod_nxt      = prod_r;
    last_time_nxt = last_time_r;
    last_net_nxt  = last_net_r;
    last_slot_nxt = last_slot_r;
    primed_nxt    = primed_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_value_nxt = out_value_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = {exp_r, mant_r};
    mem_raddr     = last_slot_r;

    slot_w      = rem_r[AW-1:0];
    ms_w        = now_r - last_time_r;
    delta_w     = 42'(net_r) - 42'(last_net_r);
    pdiff_w     = 25'(in_req.import_power_w) - 25'(in_req.export_power_w);
    back_slot_w = GW'(slot_w) + GW'(DEPTH) - GW'(lag_r);
    if (back_slot_w >= GW'(DEPTH)) begin
      back_slot_w = back_slot_w - GW'(DEPTH);
    end
    rcp_time_w  = 65'(now_r) * 65'(SLOT_RCP);
    rcp_ring_w  = 65'(dvd_r[31:0]) * 65'(RING_RCP);

    unique case (state_r)
      sphr_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        idx_nxt   = next_idx_w;
        if (idx_r == AW'(DEPTH - 1)) begin
          state_nxt = sphr_pkg::S_IDLE;
        end
      end

      sphr_pkg::S_IDLE: begin
        if (in_req.valid) begin
          req_type_nxt = in_req.req_type;
          now_nxt      = in_req.now_ms;
          est_nxt      = in_req.counter_estimated;
          net_nxt      = 41'(in_req.import_counter_wh) - 41'(in_req.export_counter_wh);
          lag_nxt      = in_req.lag_slots;
          back_nxt     = 32'({16'd0, in_req.lag_slots} * 32'(SAMPLE_MS));
          // power-given value prepared now, used only on that path
          neg_nxt      = pdiff_w[24];
          mag_nxt      = 32'(pdiff_w[24] ? -pdiff_w : pdiff_w);
          rem_nxt      = '0;
          cnt_nxt      = '0;
          state_nxt    = sphr_pkg::S_SLOT_A;
        end
      end

      sphr_pkg::S_SLOT_A: begin
        // sample index = now / SAMPLE_MS
        dvd_nxt   = {32'd0, 32'(rcp_time_w >> SLOT_SH)};
        cnt_nxt   = '0;
        state_nxt = sphr_pkg::S_SLOT_B;
      end

      sphr_pkg::S_SLOT_B: begin
        // sample index mod DEPTH: quotient first, then remainder
        if (cnt_r == '0) begin
          acc_nxt = {32'd0, 32'(rcp_ring_w >> RING_SH)};
          cnt_nxt = 7'd1;
        end else begin
          rem_nxt   = dvd_r[31:0] - acc_r[31:0] * 32'(DEPTH);
          cnt_nxt   = '0;
          state_nxt = sphr_pkg::S_DECIDE;
        end
      end

      sphr_pkg::S_PDIV, sphr_pkg::S_MDIV: begin
        dvd_nxt = dvd_s;
        rem_nxt = rem_s[31:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'd63) begin
          cnt_nxt = '0;
          priority case (state_r)
            sphr_pkg::S_PDIV: state_nxt = sphr_pkg::S_PSAT;
            default: begin
              mant_nxt  = neg_r ? -dvd_s[7:0] : dvd_s[7:0];
              state_nxt = sphr_pkg::S_FSTART;
            end
          endcase
        end
      end

      sphr_pkg::S_DECIDE: begin
        slot_nxt = slot_w;
        exp_nxt  = '0;
        if (req_type_r) begin
          if (({1'b0, lag_r} > 17'(DEPTH)) || (back_r > now_r)) begin
            prod_nxt  = '0;
            state_nxt = sphr_pkg::S_QOUT;
          end else begin
            mem_raddr = ((now_r - back_r) > last_time_r) ? last_slot_r
                                                         : back_slot_w[AW-1:0];
            state_nxt = sphr_pkg::S_QMUL;
          end
        end else if (!primed_r) begin
          primed_nxt    = 1'b1;
          last_time_nxt = now_r;
          last_net_nxt  = net_r;
          last_slot_nxt = slot_w;
          state_nxt     = sphr_pkg::S_IDLE;
        end else if (est_r && (slot_w == last_slot_r)) begin
          state_nxt = sphr_pkg::S_IDLE;
        end else if (est_r) begin
          if (ms_w == '0) begin
            neg_nxt   = 1'b0;
            mag_nxt   = '0;
            state_nxt = sphr_pkg::S_EXP;
          end else begin
            neg_nxt   = delta_w[41];
            dmag_nxt  = delta_w[41] ? 42'(-delta_w) : 42'(delta_w);
            dsr_nxt   = ms_w;
            acc_nxt   = '0;
            cnt_nxt   = 7'd21;
            state_nxt = sphr_pkg::S_MUL;
          end
        end else begin
          state_nxt = sphr_pkg::S_EXP;
        end
      end

      sphr_pkg::S_MUL: begin
        // MSB-first shift-add by 3600000
        acc_nxt = {acc_r[62:0], 1'b0} +
                  (sphr_pkg::MS_PER_HOUR[cnt_r[4:0]] ? 64'(dmag_r) : 64'd0);
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          dvd_nxt   = acc_nxt;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = sphr_pkg::S_PDIV;
        end
      end

      sphr_pkg::S_PSAT: begin
        if (neg_r) begin
          mag_nxt = (dvd_r > 64'h8000_0000) ? 32'h8000_0000 : dvd_r[31:0];
        end else begin
          mag_nxt = (dvd_r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dvd_r[31:0];
        end
        state_nxt = sphr_pkg::S_EXP;
      end

      sphr_pkg::S_EXP: begin
        if (64'(mag_r) < sphr_pkg::fit_limit(exp_r, neg_r)) begin
          if (exp_r == '0) begin
            mant_nxt  = neg_r ? -mag_r[7:0] : mag_r[7:0];
            state_nxt = sphr_pkg::S_FSTART;
          end else begin
            dvd_nxt   = {32'd0, mag_r};
            dsr_nxt   = 32'(sphr_pkg::pow10(exp_r));
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = sphr_pkg::S_MDIV;
          end
        end else begin
          exp_nxt = exp_r + 1'b1;
        end
      end

      sphr_pkg::S_FSTART: begin
        if (slot_r == last_slot_r) begin
          last_time_nxt = now_r;
          last_net_nxt  = net_r;
          state_nxt     = sphr_pkg::S_IDLE;
        end else begin
          idx_nxt   = (last_slot_r == AW'(DEPTH - 1)) ? '0 : last_slot_r + 1'b1;
          state_nxt = sphr_pkg::S_FILL;
        end
      end

      sphr_pkg::S_FILL: begin
        mem_we  = 1'b1;
        idx_nxt = next_idx_w;
        if (idx_r == slot_r) begin
          last_time_nxt = now_r;
          last_net_nxt  = net_r;
          last_slot_nxt = slot_r;
          state_nxt     = sphr_pkg::S_IDLE;
        end
      end

      sphr_pkg::S_QMUL: begin
        prod_nxt  = 59'(signed'(rd_r[7:0])) *
                    59'(signed'({1'b0, sphr_pkg::pow10(rd_r[11:8])}));
        state_nxt = sphr_pkg::S_QOUT;
      end

      sphr_pkg::S_QOUT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          if (prod_r > 59'sh7FFF_FFFF) begin
            out_value_nxt = 32'sh7FFF_FFFF;
          end else if (prod_r < -59'sh8000_0000) begin
            out_value_nxt = 32'sh8000_0000;
          end else begin
            out_value_nxt = prod_r[31:0];
          end
          state_nxt = sphr_pkg::S_IDLE;
        end
      end

      default: state_nxt = sphr_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTH
  // slot memory is only written by the clearing sweep or a fill
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == sphr_pkg::S_CLEAR || state_r == sphr_pkg::S_FILL))
    else $error("slot write outside clear/fill");

  // a result appears only from the query output step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sphr_pkg::S_QOUT)
    else $error("result raised outside query output");

  // mantissa division only for a nonzero exponent that fits 32-bit divisor
  a_exp_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sphr_pkg::S_MDIV) |-> (exp_r != '0 && exp_r <= 4'd9))
    else $error("exponent out of range in mantissa division");

  // fill index stays inside the ring
  a_fill_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sphr_pkg::S_FILL) |-> (32'(idx_r) < 32'(DEPTH)))
    else $error("fill index beyond ring");
`endif

endmodule
